// ===== rtl/pgs_pkg.sv =====
// Shared types, constants and the arctangent table of the pursuit guidance step unit.
`timescale 1ns / 1ps
package pgs_pkg;

    // Width of the CORDIC datapath, angle width.
    localparam int CW = 42;
    localparam int ZW = 32;

    localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
    localparam logic [63:0] TURN_TO_BAU   = 64'd2734261102;
    localparam logic signed [24:0] INV_GAIN = 25'sd10188014;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TURN_RATE = 2'd0;
    localparam logic [1:0] CFG_BOUND_X   = 2'd1;
    localparam logic [1:0] CFG_BOUND_Y   = 2'd2;

    // Item context that travels alongside the arithmetic.
    typedef struct packed {
        logic signed [20:0] px;
        logic signed [20:0] py;
        logic signed [18:0] vx;
        logic signed [18:0] vy;
        logic [15:0]        dt;
        logic [20:0]        life;
        logic               alive;
    } t_ctx;

    function automatic logic [31:0] atan_bau(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/pgs_cordic_iter.sv =====
// One CORDIC micro-rotation, shared by vectoring and rotation mode.
`timescale 1ns / 1ps
module pgs_cordic_iter #(
    parameter int IDX = 0
) (
    input  logic                         i_rot,
    input  logic signed [pgs_pkg::CW-1:0] i_x,
    input  logic signed [pgs_pkg::CW-1:0] i_y,
    input  logic [pgs_pkg::ZW-1:0]        i_z,
    output logic signed [pgs_pkg::CW-1:0] o_x,
    output logic signed [pgs_pkg::CW-1:0] o_y,
    output logic [pgs_pkg::ZW-1:0]        o_z
);
    import pgs_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 up;

    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;
    // Vectoring turns up when y is negative; rotation turns up while z is below a half turn.
    assign up = i_rot ? !i_z[ZW-1] : i_y[CW-1];

    always_comb begin
        if (up) begin
            o_x = i_x - ys;
            o_y = i_y + xs;
            o_z = i_z - atan_bau(IDX);
        end else begin
            o_x = i_x + ys;
            o_y = i_y - xs;
            o_z = i_z + atan_bau(IDX);
        end
    end

endmodule

// ===== rtl/pursuit_guidance_step_unit.sv =====
// Top level of the pursuit guidance step unit: a fully pipelined body update.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | i_valid / o_ready         | i_pos_*, i_vel_*, i_target_*, i_life_left, ...
//  output   | o_valid / i_ready         | o_new_pos_*, o_new_vel_*, o_new_life, ...
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item enters per cycle while the output is not stalled; each item passes through
// the preparation stages, the two CORDIC pipelines (vectoring, then rotation) and the
// turn, gain and position stages.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module pursuit_guidance_step_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [20:0] i_pos_x,
    input  logic signed [20:0] i_pos_y,
    input  logic signed [18:0] i_vel_x,
    input  logic signed [18:0] i_vel_y,
    input  logic signed [20:0] i_target_x,
    input  logic signed [20:0] i_target_y,
    input  logic               i_target_valid,
    input  logic [20:0]        i_life_left,
    input  logic [15:0]        i_time_step,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [20:0] o_new_pos_x,
    output logic signed [20:0] o_new_pos_y,
    output logic signed [18:0] o_new_vel_x,
    output logic signed [18:0] o_new_vel_y,
    output logic [20:0]        o_new_life,
    output logic               o_still_active,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import pgs_pkg::*;

    localparam int N   = CORDIC_STEPS;
    localparam int NST = 2 * N + 8;
    localparam int HW  = CW - 16;

    localparam int S_D1 = N + 2;
    localparam int S_D2 = N + 3;
    localparam int S_G1 = 2 * N + 4;
    localparam int S_G2 = 2 * N + 5;
    localparam int S_P1 = 2 * N + 6;

    logic [15:0] r_turn_rate;
    logic [11:0] r_bound_x;
    logic [11:0] r_bound_y;

    logic           en;
    logic [NST-1:0] r_vld;
    t_ctx           r_ctx [NST-1];
    t_ctx           n_ctx;

    assign en          = !r_vld[NST-1] || i_ready;
    assign o_ready     = en;
    assign o_valid     = r_vld[NST-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_rate <= 16'd12288;
            r_bound_x   <= 12'd600;
            r_bound_y   <= 12'd360;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TURN_RATE: r_turn_rate <= i_cfg_data;
                CFG_BOUND_X:   r_bound_x   <= i_cfg_data[11:0];
                CFG_BOUND_Y:   r_bound_y   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_comb begin
        n_ctx.px    = i_pos_x;
        n_ctx.py    = i_pos_y;
        n_ctx.vx    = i_vel_x;
        n_ctx.vy    = i_vel_y;
        n_ctx.dt    = i_time_step;
        n_ctx.alive = i_life_left > 21'(i_time_step);
        n_ctx.life  = n_ctx.alive ? i_life_left - 21'(i_time_step) : 21'd0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0] <= n_ctx;
        end
    end

    for (genvar s = 1; s < NST - 1; s++) begin : g_ctx
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctx[s] <= r_ctx[s-1];
            end
        end
    end

    // Stage 0: target offset and the turn-rate product.
    logic signed [21:0] r_dx;
    logic signed [21:0] r_dy;
    logic [31:0]        r_rd;
    logic               r_tv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= {i_target_x[20], i_target_x} - {i_pos_x[20], i_pos_x};
            r_dy <= {i_target_y[20], i_target_y} - {i_pos_y[20], i_pos_y};
            r_rd <= 32'(r_turn_rate) * 32'(i_time_step);
            r_tv <= i_target_valid;
        end
    end

    // Stage 1: squared distance, turn limit product and CORDIC preparation.
    logic signed [43:0]   dx44;
    logic signed [43:0]   dy44;
    logic signed [43:0]   r_sqx;
    logic signed [43:0]   r_sqy;
    logic [63:0]          r_limp;
    logic                 r_sb;
    logic signed [CW-1:0] r_ax [N+1];
    logic signed [CW-1:0] r_ay [N+1];
    logic [ZW-1:0]        r_az [N+1];
    logic signed [CW-1:0] r_bx [N+1];
    logic signed [CW-1:0] r_by [N+1];
    logic [ZW-1:0]        r_bz [N+1];
    logic signed [CW-1:0] tx0;
    logic signed [CW-1:0] ty0;
    logic signed [CW-1:0] vx0;
    logic signed [CW-1:0] vy0;

    assign dx44 = 44'(r_dx);
    assign dy44 = 44'(r_dy);
    assign tx0  = CW'(r_dx) <<< 16;
    assign ty0  = CW'(r_dy) <<< 16;
    assign vx0  = CW'(r_ctx[0].vx) <<< 16;
    assign vy0  = CW'(r_ctx[0].vy) <<< 16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx  <= dx44 * dx44;
            r_sqy  <= dy44 * dy44;
            r_limp <= 64'(r_rd) * TURN_TO_BAU;
            r_sb   <= r_tv && r_ctx[0].alive
                      && !(r_ctx[0].vx == 19'sd0 && r_ctx[0].vy == 19'sd0);
            // A left half-plane vector is mirrored and starts at a half turn.
            if (tx0 < 0) begin
                r_ax[0] <= -tx0;
                r_ay[0] <= -ty0;
                r_az[0] <= HALF_TURN;
            end else begin
                r_ax[0] <= tx0;
                r_ay[0] <= ty0;
                r_az[0] <= '0;
            end
            if (vx0 < 0) begin
                r_bx[0] <= -vx0;
                r_by[0] <= -vy0;
                r_bz[0] <= HALF_TURN;
            end else begin
                r_bx[0] <= vx0;
                r_by[0] <= vy0;
                r_bz[0] <= '0;
            end
        end
    end

    // Vectoring stages for both directions, with steer flag and limit carried along.
    logic          r_vs [N];
    logic [31:0]   r_vl [N];
    logic [33:0]   limq;
    logic [44:0]   dist2;

    assign limq  = r_limp[63:30];
    assign dist2 = 45'(r_sqx) + 45'(r_sqy);

    for (genvar k = 0; k < N; k++) begin : g_vec
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic [ZW-1:0]        az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [ZW-1:0]        bz;

        pgs_cordic_iter #(.IDX(k)) u_ta (
            .i_rot(1'b0), .i_x(r_ax[k]), .i_y(r_ay[k]), .i_z(r_az[k]),
            .o_x(ax), .o_y(ay), .o_z(az)
        );
        pgs_cordic_iter #(.IDX(k)) u_va (
            .i_rot(1'b0), .i_x(r_bx[k]), .i_y(r_by[k]), .i_z(r_bz[k]),
            .o_x(bx), .o_y(by), .o_z(bz)
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ax[k+1] <= ax;
                r_ay[k+1] <= ay;
                r_az[k+1] <= az;
                r_bx[k+1] <= bx;
                r_by[k+1] <= by;
                r_bz[k+1] <= bz;
            end
        end

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_vs[0] <= r_sb && (dist2 >= 45'd65536);
                    r_vl[0] <= (limq > 34'(HALF_TURN)) ? HALF_TURN : limq[31:0];
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_vs[k] <= r_vs[k-1];
                    r_vl[k] <= r_vl[k-1];
                end
            end
        end
    end

    // D1: signed turn and its magnitude.
    logic [31:0] d_ang;
    logic        d_neg;
    logic [31:0] r_dm;
    logic        r_dn;
    logic [31:0] r_dl;
    logic        r_ds;

    assign d_ang = r_az[N] - r_bz[N];
    assign d_neg = d_ang > HALF_TURN;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm <= d_neg ? -d_ang : d_ang;
            r_dn <= d_neg;
            r_dl <= r_vl[N-1];
            r_ds <= r_vs[N-1];
        end
    end

    // D2: limit the turn, fold wide turns, and load the rotation pipeline.
    logic [31:0]          lmt;
    logic [31:0]          zt;
    logic signed [CW-1:0] rx0;
    logic signed [CW-1:0] ry0;
    logic signed [CW-1:0] r_rx [N+1];
    logic signed [CW-1:0] r_ry [N+1];
    logic [ZW-1:0]        r_rz [N+1];
    logic                 r_rt [N+1];

    assign lmt = (r_dm > r_dl) ? r_dl : r_dm;
    assign zt  = r_dn ? -lmt : lmt;
    assign rx0 = CW'(r_ctx[S_D1].vx) <<< 16;
    assign ry0 = CW'(r_ctx[S_D1].vy) <<< 16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt[0] <= r_ds && (lmt != 32'd0);
            if (zt > QUARTER_TURN && zt < THREE_QUARTER) begin
                r_rx[0] <= -rx0;
                r_ry[0] <= -ry0;
                r_rz[0] <= zt + HALF_TURN;
            end else begin
                r_rx[0] <= rx0;
                r_ry[0] <= ry0;
                r_rz[0] <= zt;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic [ZW-1:0]        qz;

        pgs_cordic_iter #(.IDX(k)) u_rot (
            .i_rot(1'b1), .i_x(r_rx[k]), .i_y(r_ry[k]), .i_z(r_rz[k]),
            .o_x(qx), .o_y(qy), .o_z(qz)
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[k+1] <= qx;
                r_ry[k+1] <= qy;
                r_rz[k+1] <= qz;
                r_rt[k+1] <= r_rt[k];
            end
        end
    end

    // G1: inverse gain as two partial products per axis.
    logic signed [HW+24:0] r_phx;
    logic signed [HW+24:0] r_phy;
    logic [39:0]           r_plx;
    logic [39:0]           r_ply;
    logic                  r_grt;
    logic signed [HW-1:0]  hx;
    logic signed [HW-1:0]  hy;

    assign hx = r_rx[N][CW-1:16];
    assign hy = r_ry[N][CW-1:16];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phx <= hx * INV_GAIN;
            r_phy <= hy * INV_GAIN;
            r_plx <= 40'(r_rx[N][15:0]) * 40'(INV_GAIN);
            r_ply <= 40'(r_ry[N][15:0]) * 40'(INV_GAIN);
            r_grt <= r_rt[N];
        end
    end

    // G2: combine, round at bit 40, saturate; keep the velocity if no turn.
    logic signed [65:0] sgx;
    logic signed [65:0] sgy;
    logic signed [25:0] qgx;
    logic signed [25:0] qgy;
    logic signed [18:0] cgx;
    logic signed [18:0] cgy;
    logic signed [18:0] r_nvx;
    logic signed [18:0] r_nvy;

    assign sgx = (66'(r_phx) <<< 16) + 66'(r_plx) + (66'sd1 <<< 39);
    assign sgy = (66'(r_phy) <<< 16) + 66'(r_ply) + (66'sd1 <<< 39);
    assign qgx = sgx[65:40];
    assign qgy = sgy[65:40];

    always_comb begin
        if (qgx < -26'sd262144)     cgx = -19'sd262144;
        else if (qgx > 26'sd262143) cgx = 19'sd262143;
        else                        cgx = qgx[18:0];
        if (qgy < -26'sd262144)     cgy = -19'sd262144;
        else if (qgy > 26'sd262143) cgy = 19'sd262143;
        else                        cgy = qgy[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nvx <= r_grt ? cgx : r_ctx[S_G1].vx;
            r_nvy <= r_grt ? cgy : r_ctx[S_G1].vy;
        end
    end

    // P1: position step products.
    logic signed [35:0] r_sx;
    logic signed [35:0] r_sy;
    logic signed [18:0] r_pvx;
    logic signed [18:0] r_pvy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx  <= r_nvx * $signed({1'b0, r_ctx[S_G2].dt});
            r_sy  <= r_nvy * $signed({1'b0, r_ctx[S_G2].dt});
            r_pvx <= r_nvx;
            r_pvy <= r_nvy;
        end
    end

    // P2: move, check the arena, saturate; this is the output register.
    logic signed [35:0] rsx;
    logic signed [35:0] rsy;
    logic signed [22:0] nx;
    logic signed [22:0] ny;
    logic signed [22:0] bxs;
    logic signed [22:0] bys;
    logic               inside_box;
    logic signed [20:0] cx;
    logic signed [20:0] cy;
    t_ctx               pc;

    assign pc  = r_ctx[S_P1];
    assign rsx = (r_sx + 36'sd32768) >>> 16;
    assign rsy = (r_sy + 36'sd32768) >>> 16;
    assign nx  = 23'(pc.px) + 23'($signed(rsx[19:0]));
    assign ny  = 23'(pc.py) + 23'($signed(rsy[19:0]));
    assign bxs = $signed({3'b000, r_bound_x, 8'h00});
    assign bys = $signed({3'b000, r_bound_y, 8'h00});
    assign inside_box = !(nx < -bxs || nx > bxs || ny < -bys || ny > bys);

    always_comb begin
        if (nx < -23'sd1048576)     cx = -21'sd1048576;
        else if (nx > 23'sd1048575) cx = 21'sd1048575;
        else                        cx = nx[20:0];
        if (ny < -23'sd1048576)     cy = -21'sd1048576;
        else if (ny > 23'sd1048575) cy = 21'sd1048575;
        else                        cy = ny[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (pc.alive) begin
                o_new_pos_x    <= cx;
                o_new_pos_y    <= cy;
                o_new_vel_x    <= r_pvx;
                o_new_vel_y    <= r_pvy;
                o_still_active <= inside_box;
            end else begin
                o_new_pos_x    <= pc.px;
                o_new_pos_y    <= pc.py;
                o_new_vel_x    <= pc.vx;
                o_new_vel_y    <= pc.vy;
                o_still_active <= 1'b0;
            end
            o_new_life <= pc.life;
        end
    end

endmodule

// ===== rtl/pgs_checker.sv =====
// Port-level checks of the pursuit guidance step unit and their bind.
`timescale 1ns / 1ps
module pgs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [20:0] o_new_pos_x,
    input logic [20:0]        o_new_life,
    input logic               o_still_active
);

    // A result that is not taken holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_pos_x) && $stable(o_new_life))
        else $error("stalled result changed");

    // A body with no life left is never reported alive.
    a_life: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_life == 21'd0 |-> !o_still_active)
        else $error("expired body reported active");

    // After reset no result is shown.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A held result blocks new items.
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("item accepted while output stalled");

endmodule

bind pursuit_guidance_step_unit pgs_checker u_pgs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_new_pos_x(o_new_pos_x),
    .o_new_life(o_new_life),
    .o_still_active(o_still_active)
);

// ===== bench/tb_pursuit_guidance_step_unit.sv =====
// Self-checking testbench for the pursuit guidance step unit.
`timescale 1ns / 1ps
module tb_pursuit_guidance_step_unit;
    import pgs_pkg::*;

    localparam int STEPS       = 16;
    localparam int LATENCY     = 2 * STEPS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1000;

    typedef struct {
        logic signed [20:0] px, py;
        logic signed [18:0] vx, vy;
        logic signed [20:0] tx, ty;
        logic               tvalid;
        logic [20:0]        life;
        logic [15:0]        dt;
    } body_t;

    typedef struct {
        logic signed [20:0] px, py;
        logic signed [18:0] vx, vy;
        logic [20:0]        life;
        logic               active;
    } update_t;

    typedef struct {
        body_t   body;
        logic    typed;
        update_t want;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = CFG_TURN_RATE;
    logic [15:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_cfg_ready, o_still_active;
    logic signed [20:0] o_new_pos_x, o_new_pos_y;
    logic signed [18:0] o_new_vel_x, o_new_vel_y;
    logic [20:0] o_new_life;

    body_t   drv = '{default: '0};
    update_t pending_updates[$];
    logic [15:0] turn_rate = 16'd12288;
    logic [11:0] half_w = 12'd600, half_h = 12'd360;
    int cycles = 0, failures = 0, n_sent = 0, n_checked = 0, n_retired = 0;
    int stall_left = 0;
    logic cur_typed = 1'b0;
    update_t cur_want;

    logic [31:0] atan_lut[STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861};

    always #6 i_clk = ~i_clk;

    pursuit_guidance_step_unit #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_pos_x(drv.px), .i_pos_y(drv.py), .i_vel_x(drv.vx), .i_vel_y(drv.vy),
        .i_target_x(drv.tx), .i_target_y(drv.ty), .i_target_valid(drv.tvalid),
        .i_life_left(drv.life), .i_time_step(drv.dt),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_new_pos_x(o_new_pos_x), .o_new_pos_y(o_new_pos_y),
        .o_new_vel_x(o_new_vel_x), .o_new_vel_y(o_new_vel_y),
        .o_new_life(o_new_life), .o_still_active(o_still_active),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Binary angle of a vector, 2^32 units per turn.
    function automatic logic [31:0] heading(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = '0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_lut[i];
            end else begin
                x -= ys; y += xs; z -= atan_lut[i];
            end
        end
        return z;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void turn_velocity(inout longint vx, inout longint vy,
                                          input logic [31:0] z);
        longint x, y, xs, ys;
        x = vx * 65536;
        y = vy * 65536;
        // Turns past a quarter circle are folded by flipping the vector.
        if (z > QUARTER_TURN && z < THREE_QUARTER) begin
            x = -x;
            y = -y;
            z += HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z < HALF_TURN) begin
                x -= ys; y += xs; z -= atan_lut[i];
            end else begin
                x += ys; y -= xs; z += atan_lut[i];
            end
        end
        x = (x * 10188014 + (longint'(1) << 39)) >>> 40;
        y = (y * 10188014 + (longint'(1) << 39)) >>> 40;
        vx = sat(x, -262144, 262143);
        vy = sat(y, -262144, 262143);
    endfunction

    function automatic update_t advance_body(body_t b);
        update_t u;
        longint px, py, vx, vy, dx, dy, bx, by, dt;
        logic [63:0] lim;
        logic [31:0] d, mag;
        logic neg;
        px = b.px; py = b.py; vx = b.vx; vy = b.vy; dt = b.dt;
        u.life = '0;
        u.active = 1'b0;
        if (b.life > b.dt) begin
            bx = longint'(half_w) * 256;
            by = longint'(half_h) * 256;
            u.life = b.life - b.dt;
            if (b.tvalid && !(vx == 0 && vy == 0)) begin
                dx = longint'(b.tx) - px;
                dy = longint'(b.ty) - py;
                if (dx * dx + dy * dy >= 65536) begin
                    lim = ((64'(turn_rate) * 64'(b.dt)) * TURN_TO_BAU) >> 30;
                    d = heading(dx, dy) - heading(vx, vy);
                    neg = d > HALF_TURN;
                    mag = neg ? -d : d;
                    if (lim > 64'(HALF_TURN)) lim = 64'(HALF_TURN);
                    if (64'(mag) > lim) mag = lim[31:0];
                    if (mag != 0) turn_velocity(vx, vy, neg ? -mag : mag);
                end
            end
            px += (vx * dt + 32768) >>> 16;
            py += (vy * dt + 32768) >>> 16;
            u.active = !(px < -bx || px > bx || py < -by || py > by);
            px = sat(px, -1048576, 1048575);
            py = sat(py, -1048576, 1048575);
        end
        u.px = 21'(px); u.py = 21'(py); u.vx = 19'(vx); u.vy = 19'(vy);
        return u;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Scoreboard, register shadow and cycle limit, all sampled at the rising edge.
    always @(posedge i_clk) begin
        update_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_pursuit_guidance_step_unit NOT OK");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TURN_RATE: turn_rate = i_cfg_data;
                    CFG_BOUND_X:   half_w = i_cfg_data[11:0];
                    CFG_BOUND_Y:   half_h = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                stall_left = $urandom_range(0, 9);
                if (pending_updates.size() == 0) begin
                    $error("result with no item outstanding");
                    failures++;
                end else begin
                    w = pending_updates.pop_front();
                    check_field("new_pos_x", w.px, o_new_pos_x);
                    check_field("new_pos_y", w.py, o_new_pos_y);
                    check_field("new_vel_x", w.vx, o_new_vel_x);
                    check_field("new_vel_y", w.vy, o_new_vel_y);
                    check_field("new_life", w.life, o_new_life);
                    check_field("still_active", w.active, o_still_active);
                    if (!w.active) n_retired++;
                    n_checked++;
                end
            end
            if (i_valid && o_ready) begin
                w = advance_body(drv);
                // Hand-typed rows must agree with the predictor as well.
                if (cur_typed && w != cur_want) begin
                    $error("typed row %0d disagrees with prediction", n_sent);
                    failures++;
                    w = cur_want;
                end
                pending_updates = {pending_updates, w};
                n_sent++;
            end
        end
    end

    // Output side back-pressure: a random stall before each item.
    logic free_run = 1'b0;
    always @(negedge i_clk) begin
        if (stall_left > 0 && !free_run) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= i_rst_n;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Presents one item; i_valid stays high into the next item when no gap is drawn.
    task automatic send_body(body_t b, logic typed, update_t want);
        int gap;
        gap = free_run ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        drv = b;
        cur_typed = typed;
        cur_want = want;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic finish_sending();
        @(negedge i_clk);
        i_valid <= 1'b0;
        cur_typed = 1'b0;
    endtask

    function automatic body_t random_body(logic clean);
        body_t b;
        if (!clean) begin
            b.px = 21'($urandom); b.py = 21'($urandom);
            b.vx = 19'($urandom); b.vy = 19'($urandom);
            b.tx = 21'($urandom); b.ty = 21'($urandom); b.tvalid = 1'($urandom);
            b.life = 21'($urandom); b.dt = 16'($urandom);
            return b;
        end
        // Live body inside the arena chasing a target somewhere nearby.
        b.px = 21'($signed($urandom_range(0, 2 * 256 * 400)) - 256 * 400);
        b.py = 21'($signed($urandom_range(0, 2 * 256 * 300)) - 256 * 300);
        b.vx = 19'($signed($urandom_range(0, 2 * 60000)) - 60000);
        b.vy = 19'($signed($urandom_range(0, 2 * 60000)) - 60000);
        b.tx = 21'($signed($urandom_range(0, 2 * 256 * 700)) - 256 * 700);
        b.ty = 21'($signed($urandom_range(0, 2 * 256 * 500)) - 256 * 500);
        if ($urandom_range(0, 9) == 0) begin
            b.tx = 21'(b.px + $signed($urandom_range(0, 400)) - 200);
            b.ty = 21'(b.py + $signed($urandom_range(0, 400)) - 200);
        end
        b.tvalid = $urandom_range(0, 7) != 0;
        b.dt = 16'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 2000));
        b.life = $urandom_range(0, 20) == 0 ? 21'(b.dt) : 21'($urandom);
        return b;
    endfunction

    row_t rows[] = '{
        // Expired with zero life and zero step: inputs pass straight through.
        '{'{21'sd1000, -21'sd1000, 19'sd500, -19'sd500, 21'sd0, 21'sd0, 1'b1, 21'd0, 16'd0},
          1'b1, '{21'sd1000, -21'sd1000, 19'sd500, -19'sd500, 21'd0, 1'b0}},
        // Life equal to the step also expires; field extremes.
        '{'{-21'sd1048576, 21'sd1048575, -19'sd262144, 19'sd262143,
            21'sd1048575, -21'sd1048576, 1'b1, 21'd65535, 16'd65535},
          1'b1, '{-21'sd1048576, 21'sd1048575, -19'sd262144, 19'sd262143, 21'd0, 1'b0}},
        // Still body at the origin: only the life moves.
        '{'{21'sd0, 21'sd0, 19'sd0, 19'sd0, 21'sd5000, 21'sd5000, 1'b1, 21'd2097151, 16'd65535},
          1'b1, '{21'sd0, 21'sd0, 19'sd0, 19'sd0, 21'd2031616, 1'b1}},
        // No target, zero step.
        '{'{21'sd256, 21'sd512, 19'sd9000, -19'sd9000, 21'sd0, 21'sd0, 1'b0, 21'd100, 16'd0},
          1'b1, '{21'sd256, 21'sd512, 19'sd9000, -19'sd9000, 21'd100, 1'b1}},
        // Target closer than one unit.
        '{'{21'sd0, 21'sd0, 19'sd256, 19'sd0, 21'sd100, 21'sd100, 1'b1, 21'd70000, 16'd0},
          1'b1, '{21'sd0, 21'sd0, 19'sd256, 19'sd0, 21'd70000, 1'b1}},
        // Out of bounds on x, then on y: position kept, body retired.
        '{'{21'sd153601, 21'sd0, 19'sd0, 19'sd0, 21'sd0, 21'sd0, 1'b0, 21'd2, 16'd1},
          1'b1, '{21'sd153601, 21'sd0, 19'sd0, 19'sd0, 21'd1, 1'b0}},
        '{'{21'sd0, -21'sd92161, 19'sd0, 19'sd0, 21'sd0, 21'sd0, 1'b0, 21'd2, 16'd1},
          1'b1, '{21'sd0, -21'sd92161, 19'sd0, 19'sd0, 21'd1, 1'b0}},
        // Target exactly behind: a half turn counts as counterclockwise.
        '{'{21'sd0, 21'sd0, 19'sd25600, 19'sd0, -21'sd25600, 21'sd0, 1'b1, 21'd65536, 16'd65535},
          1'b0, '{default: '0}},
        '{'{21'sd0, 21'sd0, 19'sd25600, 19'sd0, 21'sd0, 21'sd25600, 1'b1, 21'd65536, 16'd1000},
          1'b0, '{default: '0}},
        '{'{21'sd0, 21'sd0, 19'sd25600, 19'sd0, 21'sd0, -21'sd25600, 1'b1, 21'd65536, 16'd1000},
          1'b0, '{default: '0}},
        // Target straight ahead: zero turn.
        '{'{21'sd0, 21'sd0, 19'sd25600, 19'sd0, 21'sd51200, 21'sd0, 1'b1, 21'd65536, 16'd1000},
          1'b0, '{default: '0}},
        // Full speed in the left half plane, saturating position.
        '{'{-21'sd1048000, 21'sd1048000, -19'sd262144, 19'sd262143,
            21'sd1048575, -21'sd1048576, 1'b1, 21'd2097151, 16'd65534},
          1'b0, '{default: '0}},
        '{'{21'sd1048575, -21'sd1048576, 19'sd262143, -19'sd262144,
            -21'sd1048576, 21'sd1048575, 1'b1, 21'd2097151, 16'd65535},
          1'b0, '{default: '0}},
        '{'{21'sd1000, 21'sd2000, -19'sd1, 19'sd1, 21'sd3000, -21'sd4000, 1'b1, 21'd2, 16'd1},
          1'b0, '{default: '0}},
        '{'{-21'sd5000, 21'sd700, 19'sd0, -19'sd12345, 21'sd99999, 21'sd777, 1'b1,
            21'd300000, 16'd4000}, 1'b0, '{default: '0}}
    };

    initial begin
        update_t none;
        logic [15:0] rates[4];
        logic [15:0] wx[4];
        logic [15:0] wy[4];
        none = '{default: '0};
        rates = '{16'd65535, 16'd0, 16'd1, 16'd0};
        wx = '{16'd4095, 16'd0, 16'd600, 16'd0};
        wy = '{16'd4095, 16'd4095, 16'd0, 16'd0};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) send_body(rows[r].body, rows[r].typed, rows[r].want);
        finish_sending();
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            rates[3] = 16'($urandom);
            wx[3] = 16'($urandom_range(1, 4095));
            wy[3] = 16'($urandom_range(1, 4095));
            if (phase < 4) begin
                write_reg(CFG_TURN_RATE, rates[phase]);
                write_reg(CFG_BOUND_X, wx[phase]);
                write_reg(CFG_BOUND_Y, wy[phase]);
            end else begin
                write_reg(CFG_TURN_RATE, 16'd12288);
                write_reg(CFG_BOUND_X, 16'd600);
                write_reg(CFG_BOUND_Y, 16'd360);
            end
            free_run = (phase == 2);
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                send_body(random_body($urandom_range(0, 4) != 0), 1'b0, none);
                // Let the pipeline run dry once mid-phase.
                if (k == N_RANDOM / 10) begin
                    finish_sending();
                    while (pending_updates.size() != 0) @(posedge i_clk);
                end
            end
            finish_sending();
            free_run = 1'b0;
            drain();
        end

        $display("%0d bodies sent, %0d updates checked, %0d retired", n_sent, n_checked,
                 n_retired);
        $display("covered five register settings incl. zero and full turn rate and bounds");
        if (failures == 0 && pending_updates.size() == 0) begin
            $display("tb_pursuit_guidance_step_unit OK");
        end else begin
            $display("tb_pursuit_guidance_step_unit NOT OK");
        end
        $finish;
    end

endmodule
